### rtl/iors_pkg.sv
// Package for the inner/outer restart scheduler: widths, codes, reset values and growth math.
package iors_pkg;

    localparam int CONF_W   = 32;
    localparam int LEVEL_W  = 24;
    localparam int SUM_W    = 40;
    localparam int INIT_W   = 16;
    localparam int FACTOR_W = 16;
    localparam int LIMIT_W  = 17;
    localparam int FRAC_W   = 12;
    localparam int APB_AW   = 4;
    localparam int APB_DW   = 32;

    typedef logic [1:0] t_cmd;
    typedef logic [1:0] t_reg_idx;

    localparam t_cmd CMD_BACKJUMP = 2'd0;
    localparam t_cmd CMD_CHECK    = 2'd1;
    localparam t_cmd CMD_PREPARE  = 2'd2;

    localparam t_reg_idx REG_INITIAL_INTERVAL = 2'd0;
    localparam t_reg_idx REG_GROWTH_FACTOR    = 2'd1;
    localparam t_reg_idx REG_STAGNATION_LIMIT = 2'd2;

    localparam logic [INIT_W-1:0]   RST_INITIAL_INTERVAL = 16'd100;
    localparam logic [FACTOR_W-1:0] RST_GROWTH_FACTOR    = 16'd4506;
    localparam logic [LIMIT_W-1:0]  RST_STAGNATION_LIMIT = 17'd32768;

    // x * factor in Q4.12, saturating at the interval width
    function automatic logic [CONF_W-1:0] grow(input logic [CONF_W-1:0] x,
                                                input logic [FACTOR_W-1:0] factor);
        logic [CONF_W+FACTOR_W-1:0] p;
        p = {{FACTOR_W{1'b0}}, x} * {{CONF_W{1'b0}}, factor};
        if (|p[CONF_W+FACTOR_W-1:CONF_W+FRAC_W]) begin
            return '1;
        end
        return p[CONF_W+FRAC_W-1:FRAC_W];
    endfunction

    function automatic logic [SUM_W-1:0] sat_add_sum(input logic [SUM_W-1:0] a,
                                                     input logic [LEVEL_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {{(SUM_W+1-LEVEL_W){1'b0}}, b};
        if (s[SUM_W]) begin
            return '1;
        end
        return s[SUM_W-1:0];
    endfunction

endpackage

### rtl/inner_outer_restart_scheduler_unit.sv
// Inner/outer geometric restart scheduler: top level with APB registers and the item pipeline.
//
// Takes one item per clock unless a check item is held behind a stalled result beat. An
// accepted item is evaluated against the scheduler state while it sits in the input
// register. A check item's result is captured from there in the output register, which
// drives the result beat. A check item waits in the input register while a result beat is stalled,
// and the input stalls with it. The cycle time is set by the check path: a 32x16 growth
// multiply, the inner/outer compare and the saturating target add, in parallel with the
// 17x40 stagnation product and compare. Backjump and prepare items give no result beat; a
// command code of 3 is dropped. Register writes take effect on the next prepare or check
// and are to be made while no item is in flight.
module inner_outer_restart_scheduler_unit
    import iors_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,

    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [1:0]          i_cmd,
    input  logic [CONF_W-1:0]   i_conflict_count,
    input  logic [LEVEL_W-1:0]  i_decision_level,
    input  logic [LEVEL_W-1:0]  i_jump_target_level,

    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic                o_do_restart,
    output logic                o_restart_blocked,

    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [APB_DW-1:0]   pwdata,
    output logic [APB_DW-1:0]   prdata,
    output logic                pready
);

    // configuration
    logic [INIT_W-1:0]   r_initial_interval;
    logic [FACTOR_W-1:0] r_growth_factor;
    logic [LIMIT_W-1:0]  r_stagnation_limit;

    // scheduler state
    logic [CONF_W-1:0] r_conflict_target, n_conflict_target;
    logic [CONF_W-1:0] r_inner_interval, n_inner_interval;
    logic [CONF_W-1:0] r_outer_interval, n_outer_interval;
    logic [SUM_W-1:0]  r_distance_sum, n_distance_sum;
    logic [SUM_W-1:0]  r_height_sum, n_height_sum;

    // input register
    logic               r_s1_valid;
    t_cmd               r_s1_cmd;
    logic [CONF_W-1:0]  r_s1_conflict_count;
    logic [LEVEL_W-1:0] r_s1_decision_level;
    logic [LEVEL_W-1:0] r_s1_jump_target_level;

    // output register
    logic r_out_valid;
    logic r_out_do_restart;
    logic r_out_restart_blocked;

    logic apb_wr;
    logic in_accept;
    logic out_free;
    logic s1_is_check;
    logic s1_go;
    logic s1_hit;

    logic [CONF_W-1:0]        inner_grown;
    logic [CONF_W-1:0]        outer_grown;
    logic                     wrap;
    logic [CONF_W-1:0]        inner_next;
    logic [CONF_W-1:0]        outer_next;
    logic [CONF_W:0]          target_sum;
    logic [LEVEL_W-1:0]       distance;
    logic [SUM_W+LIMIT_W-1:0] stag_lhs;
    logic [SUM_W+LIMIT_W-1:0] stag_rhs;
    logic                     blocked;

    // APB register file
    assign pready = 1'b1;
    assign apb_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_initial_interval <= RST_INITIAL_INTERVAL;
            r_growth_factor    <= RST_GROWTH_FACTOR;
            r_stagnation_limit <= RST_STAGNATION_LIMIT;
        end else if (apb_wr) begin
            unique case (t_reg_idx'(paddr[3:2]))
                REG_INITIAL_INTERVAL: r_initial_interval <= pwdata[INIT_W-1:0];
                REG_GROWTH_FACTOR:    r_growth_factor    <= pwdata[FACTOR_W-1:0];
                REG_STAGNATION_LIMIT: r_stagnation_limit <= pwdata[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (t_reg_idx'(paddr[3:2]))
            REG_INITIAL_INTERVAL: prdata = {{(APB_DW-INIT_W){1'b0}}, r_initial_interval};
            REG_GROWTH_FACTOR:    prdata = {{(APB_DW-FACTOR_W){1'b0}}, r_growth_factor};
            REG_STAGNATION_LIMIT: prdata = {{(APB_DW-LIMIT_W){1'b0}}, r_stagnation_limit};
            default:              prdata = '0;
        endcase
    end

    // flow control
    assign out_free    = !r_out_valid || !i_out_stall;
    assign s1_is_check = (r_s1_cmd == CMD_CHECK);
    assign s1_go       = r_s1_valid && (!s1_is_check || out_free);
    assign o_in_stall  = r_s1_valid && !s1_go;
    assign in_accept   = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept || s1_go) begin
            r_s1_valid <= in_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_cmd               <= i_cmd;
            r_s1_conflict_count    <= i_conflict_count;
            r_s1_decision_level    <= i_decision_level;
            r_s1_jump_target_level <= i_jump_target_level;
        end
    end

    // check path
    assign s1_hit      = r_s1_conflict_count >= r_conflict_target;
    assign inner_grown = grow(r_inner_interval, r_growth_factor);
    assign outer_grown = grow(r_outer_interval, r_growth_factor);
    assign wrap        = inner_grown >= r_outer_interval;
    assign inner_next  = wrap ? {{(CONF_W-INIT_W){1'b0}}, r_initial_interval} : inner_grown;
    assign outer_next  = wrap ? outer_grown : r_outer_interval;
    assign target_sum  = {1'b0, r_conflict_target} + {1'b0, inner_next};

    assign stag_lhs = {1'b0, r_distance_sum, {(LIMIT_W-1){1'b0}}};
    assign stag_rhs = {{LIMIT_W{1'b0}}, r_height_sum} * {{SUM_W{1'b0}}, r_stagnation_limit};
    assign blocked  = (r_height_sum != '0) && (stag_lhs > stag_rhs);

    assign distance = (r_s1_decision_level > r_s1_jump_target_level) ?
                      (r_s1_decision_level - r_s1_jump_target_level) : '0;

    always_comb begin
        n_conflict_target = r_conflict_target;
        n_inner_interval  = r_inner_interval;
        n_outer_interval  = r_outer_interval;
        n_distance_sum    = r_distance_sum;
        n_height_sum      = r_height_sum;
        if (s1_go) begin
            case (r_s1_cmd)
                CMD_BACKJUMP: begin
                    n_distance_sum = sat_add_sum(r_distance_sum, distance);
                    n_height_sum   = sat_add_sum(r_height_sum, r_s1_decision_level);
                end
                CMD_CHECK: begin
                    if (s1_hit) begin
                        n_inner_interval  = inner_next;
                        n_outer_interval  = outer_next;
                        n_conflict_target = target_sum[CONF_W] ? '1 : target_sum[CONF_W-1:0];
                        n_distance_sum    = '0;
                        n_height_sum      = '0;
                    end
                end
                CMD_PREPARE: begin
                    n_conflict_target = {{(CONF_W-INIT_W){1'b0}}, r_initial_interval};
                    n_inner_interval  = {{(CONF_W-INIT_W){1'b0}}, r_initial_interval};
                    n_outer_interval  = {{(CONF_W-INIT_W){1'b0}}, r_initial_interval};
                    n_distance_sum    = '0;
                    n_height_sum      = '0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_conflict_target <= {{(CONF_W-INIT_W){1'b0}}, RST_INITIAL_INTERVAL};
            r_inner_interval  <= {{(CONF_W-INIT_W){1'b0}}, RST_INITIAL_INTERVAL};
            r_outer_interval  <= {{(CONF_W-INIT_W){1'b0}}, RST_INITIAL_INTERVAL};
            r_distance_sum    <= '0;
            r_height_sum      <= '0;
        end else begin
            r_conflict_target <= n_conflict_target;
            r_inner_interval  <= n_inner_interval;
            r_outer_interval  <= n_outer_interval;
            r_distance_sum    <= n_distance_sum;
            r_height_sum      <= n_height_sum;
        end
    end

    // result beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= s1_go && s1_is_check;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && s1_go && s1_is_check) begin
            r_out_do_restart      <= s1_hit && !blocked;
            r_out_restart_blocked <= s1_hit && blocked;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_do_restart      = r_out_do_restart;
    assign o_restart_blocked = r_out_restart_blocked;

    // checks
    a_result_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_do_restart && o_restart_blocked))
        else $error("restart and blocked both set");

    a_check_clears_sums: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_go && s1_is_check && s1_hit) |=> (r_distance_sum == '0 && r_height_sum == '0))
        else $error("sums not cleared after target reached");

    a_prepare_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_go && r_s1_cmd == CMD_PREPARE) |=>
        (r_inner_interval == r_outer_interval && r_conflict_target == r_inner_interval))
        else $error("prepare did not load intervals");

    a_check_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && s1_is_check && r_out_valid && i_out_stall) |=> r_s1_valid)
        else $error("check item lost while result stalled");

endmodule

### dv/restart_verdict_checker.sv
// Checker for the restart scheduler: tracks registers, predicts check verdicts, compares beats.
module restart_verdict_checker
    import iors_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic [1:0]         i_cmd,
    input  logic [CONF_W-1:0]  i_conflict_count,
    input  logic [LEVEL_W-1:0] i_decision_level,
    input  logic [LEVEL_W-1:0] i_jump_target_level,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic               i_do_restart,
    input  logic               i_restart_blocked,
    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic [APB_AW-1:0]  i_paddr,
    input  logic [APB_DW-1:0]  i_pwdata,
    input  logic               i_pready,
    output int                 o_fail_count,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic do_restart;
        logic restart_blocked;
    } t_restart_verdict;

    t_restart_verdict      verdict_queue[$];
    int                    fails = 0;

    logic [INIT_W-1:0]     cfg_initial;
    logic [FACTOR_W-1:0]   cfg_factor;
    logic [LIMIT_W-1:0]    cfg_limit;

    logic [CONF_W-1:0]     target_q;
    logic [CONF_W-1:0]     inner_q;
    logic [CONF_W-1:0]     outer_q;
    logic [SUM_W-1:0]      dist_sum_q;
    logic [SUM_W-1:0]      height_sum_q;

    function automatic logic [CONF_W-1:0] scaled(input logic [CONF_W-1:0] x,
                                                  input logic [FACTOR_W-1:0] f);
        logic [47:0] prod;
        prod = ({16'b0, x} * {32'b0, f}) >> FRAC_W;
        return (prod > 48'hFFFF_FFFF) ? '1 : prod[CONF_W-1:0];
    endfunction

    function automatic logic [SUM_W-1:0] sum_sat(input logic [SUM_W-1:0] acc,
                                                  input logic [LEVEL_W-1:0] val);
        logic [SUM_W:0] s;
        s = {1'b0, acc} + (SUM_W+1)'(val);
        return s[SUM_W] ? '1 : s[SUM_W-1:0];
    endfunction

    task automatic restart_all();
        target_q     = CONF_W'(cfg_initial);
        inner_q      = CONF_W'(cfg_initial);
        outer_q      = CONF_W'(cfg_initial);
        dist_sum_q   = '0;
        height_sum_q = '0;
    endtask

    task automatic predict_item();
        logic [CONF_W:0]    tgt;
        logic [63:0]        lhs;
        logic [63:0]        rhs;
        logic               blocked;
        t_restart_verdict   v;
        case (i_cmd)
            CMD_BACKJUMP: begin
                dist_sum_q = sum_sat(dist_sum_q, (i_decision_level > i_jump_target_level) ?
                                     i_decision_level - i_jump_target_level : '0);
                height_sum_q = sum_sat(height_sum_q, i_decision_level);
            end
            CMD_PREPARE: begin
                restart_all();
            end
            CMD_CHECK: begin
                if (i_conflict_count < target_q) begin
                    v = '{do_restart: 1'b0, restart_blocked: 1'b0};
                end else begin
                    inner_q = scaled(inner_q, cfg_factor);
                    if (inner_q >= outer_q) begin
                        inner_q = CONF_W'(cfg_initial);
                        outer_q = scaled(outer_q, cfg_factor);
                    end
                    tgt      = {1'b0, target_q} + {1'b0, inner_q};
                    target_q = tgt[CONF_W] ? '1 : tgt[CONF_W-1:0];
                    lhs      = {8'b0, dist_sum_q, 16'b0};
                    rhs      = 64'(cfg_limit) * 64'(height_sum_q);
                    blocked  = (height_sum_q != '0) && (lhs > rhs);
                    dist_sum_q   = '0;
                    height_sum_q = '0;
                    v = '{do_restart: !blocked, restart_blocked: blocked};
                end
                verdict_queue.push_back(v);
            end
            default: begin
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        t_restart_verdict want;
        if (!i_rst_n) begin
            cfg_initial = RST_INITIAL_INTERVAL;
            cfg_factor  = RST_GROWTH_FACTOR;
            cfg_limit   = RST_STAGNATION_LIMIT;
            restart_all();
            verdict_queue.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (verdict_queue.size() == 0) begin
                    $error("result beat with no verdict pending");
                    fails++;
                end else begin
                    want = verdict_queue.pop_front();
                    if (i_do_restart !== want.do_restart) begin
                        $error("do_restart: expected %0b, actual %0b",
                               want.do_restart, i_do_restart);
                        fails++;
                    end
                    if (i_restart_blocked !== want.restart_blocked) begin
                        $error("restart_blocked: expected %0b, actual %0b",
                               want.restart_blocked, i_restart_blocked);
                        fails++;
                    end
                end
            end
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_reg_idx'(i_paddr[3:2]))
                    REG_INITIAL_INTERVAL: cfg_initial = i_pwdata[INIT_W-1:0];
                    REG_GROWTH_FACTOR:    cfg_factor  = i_pwdata[FACTOR_W-1:0];
                    REG_STAGNATION_LIMIT: cfg_limit   = i_pwdata[LIMIT_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                predict_item();
            end
        end
        o_pending    <= verdict_queue.size();
        o_fail_count <= fails;
    end

endmodule

### dv/tb.sv
// Testbench top for the restart scheduler: clock, reset, register setup, stimulus and verdict.
module tb
    import iors_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam t_cmd CMD_UNUSED  = 2'd3;
    localparam int   STALL_PCT   = 18;
    localparam int   WDOG_LIMIT  = 2000;
    localparam int   PHASE_BEATS = 400;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [1:0]         cmd = CMD_BACKJUMP;
    logic [CONF_W-1:0]  conflict_count = '0;
    logic [LEVEL_W-1:0] decision_level = '0;
    logic [LEVEL_W-1:0] jump_level = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic               do_restart;
    logic               restart_blocked;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [APB_AW-1:0]  paddr = '0;
    logic [APB_DW-1:0]  pwdata = '0;
    logic [APB_DW-1:0]  prdata;
    logic               pready;
    logic               calm = 1'b0;
    int                 fail_count;
    int                 pending;
    int                 idle_cycles = 0;
    int                 cur_initial = int'(RST_INITIAL_INTERVAL);

    inner_outer_restart_scheduler_unit uut (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_in_valid          (in_valid),
        .o_in_stall          (in_stall),
        .i_cmd               (cmd),
        .i_conflict_count    (conflict_count),
        .i_decision_level    (decision_level),
        .i_jump_target_level (jump_level),
        .o_out_valid         (out_valid),
        .i_out_stall         (out_stall),
        .o_do_restart        (do_restart),
        .o_restart_blocked   (restart_blocked),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready)
    );

    restart_verdict_checker checker_i (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_in_valid          (in_valid),
        .i_in_stall          (in_stall),
        .i_cmd               (cmd),
        .i_conflict_count    (conflict_count),
        .i_decision_level    (decision_level),
        .i_jump_target_level (jump_level),
        .i_out_valid         (out_valid),
        .i_out_stall         (out_stall),
        .i_do_restart        (do_restart),
        .i_restart_blocked   (restart_blocked),
        .i_psel              (psel),
        .i_penable           (penable),
        .i_pwrite            (pwrite),
        .i_paddr             (paddr),
        .i_pwdata            (pwdata),
        .i_pready            (pready),
        .o_fail_count        (fail_count),
        .o_pending           (pending)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            out_stall <= !calm && ($urandom_range(0, 99) < STALL_PCT);
        end
    end

    // watchdog: cycles with no beat on either channel
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_beat(input t_cmd c, input logic [CONF_W-1:0] cc,
                             input logic [LEVEL_W-1:0] dl, input logic [LEVEL_W-1:0] tl);
        while (!calm && $urandom_range(0, 99) < STALL_PCT) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        cmd            <= c;
        conflict_count <= cc;
        decision_level <= dl;
        jump_level     <= tl;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [APB_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(input int init_v, input int factor_v, input int limit_v);
        write_reg(REG_INITIAL_INTERVAL, APB_DW'(init_v));
        write_reg(REG_GROWTH_FACTOR, APB_DW'(factor_v));
        write_reg(REG_STAGNATION_LIMIT, APB_DW'(limit_v));
        cur_initial = init_v;
    endtask

    // solver-like traffic: prepare, then backjumps, checks on a mostly rising conflict count, prepares and other codes
    task automatic run_phase(input int beats);
        logic [CONF_W:0]    conf;
        logic [LEVEL_W-1:0] dl;
        logic [LEVEL_W-1:0] tl;
        int                 r;
        int                 step_max;
        step_max = 2 * cur_initial + 16;
        conf = '0;
        send_beat(CMD_PREPARE, $urandom, LEVEL_W'($urandom), LEVEL_W'($urandom));
        for (int n = 0; n < beats; n++) begin
            if (n == beats / 2) begin
                wait_drained();
            end
            r = $urandom_range(0, 99);
            if (r < 52) begin
                if ($urandom_range(0, 99) < 5) begin
                    dl = LEVEL_W'($urandom);
                    tl = LEVEL_W'($urandom);
                end else begin
                    dl = LEVEL_W'($urandom_range(0, 400));
                    tl = ($urandom_range(0, 99) < 85) ? LEVEL_W'($urandom_range(0, dl)) :
                         LEVEL_W'(dl + $urandom_range(0, 50));
                end
                send_beat(CMD_BACKJUMP, $urandom, dl, tl);
            end else if (r < 82) begin
                r = $urandom_range(0, 99);
                if (r < 3) begin
                    conf = {1'b0, {CONF_W{1'b1}}};
                end else if (r < 6) begin
                    conf = {1'b0, 32'($urandom)};
                end else begin
                    conf = conf + $urandom_range(0, step_max);
                    if (conf[CONF_W]) conf = {1'b0, {CONF_W{1'b1}}};
                end
                send_beat(CMD_CHECK, conf[CONF_W-1:0], LEVEL_W'($urandom),
                          LEVEL_W'($urandom));
            end else if (r < 87) begin
                conf = '0;
                send_beat(CMD_PREPARE, $urandom, LEVEL_W'($urandom), LEVEL_W'($urandom));
            end else if (r < 92) begin
                send_beat(CMD_UNUSED, $urandom, LEVEL_W'($urandom), LEVEL_W'($urandom));
            end else begin
                send_beat(t_cmd'($urandom_range(0, 3)), $urandom, LEVEL_W'($urandom),
                          LEVEL_W'($urandom));
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, reset register values
        send_beat(CMD_CHECK, 32'd0, '0, '0);
        send_beat(CMD_CHECK, 32'd99, '1, '1);
        send_beat(CMD_CHECK, 32'd100, '0, '0);
        send_beat(CMD_BACKJUMP, '0, 24'd10, 24'd2);
        send_beat(CMD_CHECK, '1, '0, '0);
        send_beat(CMD_BACKJUMP, '1, 24'd5, 24'd9);
        send_beat(CMD_CHECK, '1, '1, '1);
        send_beat(CMD_BACKJUMP, '0, '1, '1);
        send_beat(CMD_BACKJUMP, '0, '0, '1);
        send_beat(CMD_CHECK, '1, '0, '0);
        send_beat(CMD_UNUSED, '1, '1, '1);
        send_beat(CMD_UNUSED, '0, '0, '0);
        send_beat(CMD_PREPARE, '1, '1, '1);
        send_beat(CMD_CHECK, 32'd100, '0, '0);
        send_beat(CMD_BACKJUMP, '0, '1, '0);
        send_beat(CMD_CHECK, '1, '0, '0);
        send_beat(CMD_PREPARE, '0, '0, '0);
        send_beat(CMD_BACKJUMP, '0, 24'd2, 24'd1);
        send_beat(CMD_CHECK, '1, '0, '0);
        send_beat(CMD_CHECK, '0, '0, '0);

        for (int p = 0; p < 5; p++) begin
            wait_drained();
            case (p)
                0: set_config(1, 4097, 0);
                1: set_config(65535, 65535, 65536);
                2: set_config($urandom_range(1, 65535), $urandom_range(4097, 65535),
                              $urandom_range(0, 65536));
                3: set_config(0, $urandom_range(0, 4096), $urandom_range(0, 65536));
                default: set_config($urandom_range(0, 65535), $urandom_range(0, 65535),
                                    $urandom_range(0, 65536));
            endcase
            calm <= (p == 2);
            run_phase(PHASE_BEATS);
        end
        calm <= 1'b0;

        // deep backjumps at the top level, then one check
        wait_drained();
        set_config(int'(RST_INITIAL_INTERVAL), int'(RST_GROWTH_FACTOR),
                   int'(RST_STAGNATION_LIMIT));
        send_beat(CMD_PREPARE, '0, '0, '0);
        repeat (64) send_beat(CMD_BACKJUMP, $urandom, '1, '0);
        send_beat(CMD_CHECK, '1, '0, '0);

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
